/* rtl/prfa_pkg.sv */
// ----------------------------------------------------------------------------
// Per-flow rate adjuster package
// Field widths, operation and action codes, and the tag carried with each
// item between the classifier and the record update pipeline.
// ----------------------------------------------------------------------------
package prfa_pkg;

	localparam int FLOW_W  = 8;
	localparam int COUNT_W = 32;
	localparam int ACT_W   = 2;
	localparam int CFG_W   = 9;

	// Operation codes carried in the op field.
	localparam logic OP_LOAD = 1'b0;

	// Action codes reported with each result.
	localparam logic [ACT_W-1:0] ACT_HOLD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INC  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DEC  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd3;

	typedef struct packed {
		logic              op;
		logic              rejected;
		logic [FLOW_W-1:0] flow;
	} item_tag_t;

endpackage

/* rtl/prfa_fifo.sv */
// ----------------------------------------------------------------------------
// Small synchronous queue
// A register-based first-in first-out queue with full and empty flags, used
// between the classifier and the update pipeline and in front of the results.
// ----------------------------------------------------------------------------
module prfa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

/* rtl/prfa_front.sv */
// ----------------------------------------------------------------------------
// Rate adjuster front end
// Holds the active flow count, accepts input beats, checks the flow index
// against the limits and hands tagged items to the work queue.
// ----------------------------------------------------------------------------
module prfa_front #(
	parameter int MAX_FLOWS = 256,
	parameter int RATE_BITS = 20,
	parameter int ADDR_W    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [prfa_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                        push,
	output logic                        full,
	input  logic                        op,
	input  logic [prfa_pkg::FLOW_W-1:0] flow,
	input  logic [RATE_BITS-1:0]        measured_rate,
	input  logic [RATE_BITS-1:0]        load_rate,
	input  logic [RATE_BITS-1:0]        load_min,
	input  logic [RATE_BITS-1:0]        load_max,
	input  logic [RATE_BITS-1:0]        load_step,
	input  logic                        q_full,
	output logic                        q_push,
	output prfa_pkg::item_tag_t         q_tag,
	output logic [ADDR_W-1:0]           q_addr,
	output logic [RATE_BITS-1:0]        q_meas,
	output logic [RATE_BITS-1:0]        q_load_rate,
	output logic [RATE_BITS-1:0]        q_load_min,
	output logic [RATE_BITS-1:0]        q_load_max,
	output logic [RATE_BITS-1:0]        q_load_step
);

	logic [prfa_pkg::CFG_W-1:0] active_flows_q;
	logic                       beyond_active;
	logic                       beyond_table;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_flows_q <= '0;
		end else if (cfg_wr_en) begin
			active_flows_q <= cfg_wr_data;
		end
	end

	// A flow is rejected past the active count or past the table itself.
	assign beyond_active = (prfa_pkg::CFG_W'(flow) >= active_flows_q);
	assign beyond_table  = (32'(flow) >= 32'(MAX_FLOWS));

	assign full              = q_full;
	assign q_push            = push && !q_full;
	assign q_tag.op          = op;
	assign q_tag.rejected    = beyond_active || beyond_table;
	assign q_tag.flow        = flow;
	assign q_addr            = ADDR_W'(flow);
	assign q_meas            = measured_rate;
	assign q_load_rate       = load_rate;
	assign q_load_min        = load_min;
	assign q_load_max        = load_max;
	assign q_load_step       = load_step;

endmodule

/* rtl/prfa_back.sv */
// ----------------------------------------------------------------------------
// Rate adjuster back end
// Reads the flow record, works out the new rate in two stages and writes the
// record back while handing the result to the output queue.
// ----------------------------------------------------------------------------
module prfa_back #(
	parameter int MAX_FLOWS = 256,
	parameter int RATE_BITS = 20,
	parameter int ADDR_W    = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_empty,
	output logic                         in_pop,
	input  prfa_pkg::item_tag_t          in_tag,
	input  logic [ADDR_W-1:0]            in_addr,
	input  logic [RATE_BITS-1:0]         in_meas,
	input  logic [RATE_BITS-1:0]         in_load_rate,
	input  logic [RATE_BITS-1:0]         in_load_min,
	input  logic [RATE_BITS-1:0]         in_load_max,
	input  logic [RATE_BITS-1:0]         in_load_step,
	input  logic                         out_full,
	output logic                         out_push,
	output logic [prfa_pkg::FLOW_W-1:0]  out_flow,
	output logic [RATE_BITS-1:0]         out_rate,
	output logic [prfa_pkg::ACT_W-1:0]   out_action,
	output logic [prfa_pkg::COUNT_W-1:0] out_count,
	output logic                         out_rejected
);

	localparam int W     = RATE_BITS;
	localparam int CW    = prfa_pkg::COUNT_W;
	localparam int SHIFT = W + 4;
	// Reciprocal of ten, rounded up; exact floor division for any W-bit value.
	localparam logic [W:0] RECIP = (W + 1)'(((64'd1 << SHIFT) + 64'd9) / 64'd10);

	// Record memory.
	logic [W-1:0]  cur_mem  [MAX_FLOWS];
	logic [W-1:0]  min_mem  [MAX_FLOWS];
	logic [W-1:0]  max_mem  [MAX_FLOWS];
	logic [W-1:0]  step_mem [MAX_FLOWS];
	logic [CW-1:0] cnt_mem  [MAX_FLOWS];

	// Stage 1: item plus registered read data.
	logic                valid_s1;
	prfa_pkg::item_tag_t tag_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [W-1:0]        meas_s1, ld_rate_s1, ld_min_s1, ld_max_s1, ld_step_s1;
	logic [W-1:0]        rd_cur_s1, rd_min_s1, rd_max_s1, rd_step_s1;
	logic [CW-1:0]       rd_cnt_s1;
	logic                byp_s1;
	logic [W-1:0]        byp_cur_s1, byp_min_s1, byp_max_s1, byp_step_s1;
	logic [CW-1:0]       byp_cnt_s1;

	logic [W-1:0]        sel_cur, sel_min, sel_max, sel_step;
	logic [CW-1:0]       sel_cnt;
	logic [2*W:0]        prod;
	logic [W:0]          sum;

	// Stage 2: record, tenth of the rate and the raised rate.
	logic                valid_s2;
	prfa_pkg::item_tag_t tag_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic [W-1:0]        meas_s2, ld_rate_s2, ld_min_s2, ld_max_s2, ld_step_s2;
	logic [W-1:0]        cur_s2, min_s2, max_s2, step_s2, tenth_s2;
	logic [CW-1:0]       cnt_s2;
	logic [W:0]          sum_s2;

	logic                commit;
	logic                mem_we;
	logic [W-1:0]        thresh, half;
	logic [W-1:0]        wr_cur, wr_min, wr_max, wr_step;
	logic [CW-1:0]       wr_cnt;
	logic [prfa_pkg::ACT_W-1:0] res_act;
	logic [W-1:0]        res_rate;
	logic [CW-1:0]       res_cnt;

	// One item in flight; the next one is read as the current one commits.
	assign commit = valid_s2 && !out_full;
	assign in_pop = !in_empty && !valid_s1 && (!valid_s2 || commit);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cur_mem[addr_s2]  <= wr_cur;
			min_mem[addr_s2]  <= wr_min;
			max_mem[addr_s2]  <= wr_max;
			step_mem[addr_s2] <= wr_step;
			cnt_mem[addr_s2]  <= wr_cnt;
		end
		if (in_pop) begin
			rd_cur_s1  <= cur_mem[in_addr];
			rd_min_s1  <= min_mem[in_addr];
			rd_max_s1  <= max_mem[in_addr];
			rd_step_s1 <= step_mem[in_addr];
			rd_cnt_s1  <= cnt_mem[in_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= in_pop;
			valid_s2 <= valid_s1 || (valid_s2 && !commit);
			byp_s1   <= in_pop && mem_we && (in_addr == addr_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			tag_s1      <= in_tag;
			addr_s1     <= in_addr;
			meas_s1     <= in_meas;
			ld_rate_s1  <= in_load_rate;
			ld_min_s1   <= in_load_min;
			ld_max_s1   <= in_load_max;
			ld_step_s1  <= in_load_step;
			byp_cur_s1  <= wr_cur;
			byp_min_s1  <= wr_min;
			byp_max_s1  <= wr_max;
			byp_step_s1 <= wr_step;
			byp_cnt_s1  <= wr_cnt;
		end
	end

	// The record written in the cycle of the read wins over the stale read.
	assign sel_cur  = byp_s1 ? byp_cur_s1  : rd_cur_s1;
	assign sel_min  = byp_s1 ? byp_min_s1  : rd_min_s1;
	assign sel_max  = byp_s1 ? byp_max_s1  : rd_max_s1;
	assign sel_step = byp_s1 ? byp_step_s1 : rd_step_s1;
	assign sel_cnt  = byp_s1 ? byp_cnt_s1  : rd_cnt_s1;
	assign prod     = (2 * W + 1)'(sel_cur) * (2 * W + 1)'(RECIP);
	assign sum      = {1'b0, sel_cur} + {1'b0, sel_step};

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tag_s2     <= tag_s1;
			addr_s2    <= addr_s1;
			meas_s2    <= meas_s1;
			ld_rate_s2 <= ld_rate_s1;
			ld_min_s2  <= ld_min_s1;
			ld_max_s2  <= ld_max_s1;
			ld_step_s2 <= ld_step_s1;
			cur_s2     <= sel_cur;
			min_s2     <= sel_min;
			max_s2     <= sel_max;
			step_s2    <= sel_step;
			cnt_s2     <= sel_cnt;
			tenth_s2   <= W'(prod >> SHIFT);
			sum_s2     <= sum;
		end
	end

	assign thresh = cur_s2 - tenth_s2;
	assign half   = cur_s2 >> 1;

	always_comb begin
		mem_we   = 1'b0;
		wr_cur   = cur_s2;
		wr_min   = min_s2;
		wr_max   = max_s2;
		wr_step  = step_s2;
		wr_cnt   = cnt_s2 + 1'b1;
		res_act  = prfa_pkg::ACT_HOLD;
		res_rate = '0;
		res_cnt  = '0;
		if (!tag_s2.rejected) begin
			mem_we = commit;
			if (tag_s2.op == prfa_pkg::OP_LOAD) begin
				wr_cur  = ld_rate_s2;
				wr_min  = ld_min_s2;
				wr_max  = ld_max_s2;
				wr_step = ld_step_s2;
				wr_cnt  = '0;
				res_act = prfa_pkg::ACT_LOAD;
			end else if (meas_s2 >= thresh) begin
				if (cur_s2 >= max_s2) begin
					wr_cur  = max_s2;
					res_act = prfa_pkg::ACT_HOLD;
				end else begin
					wr_cur  = (sum_s2 > {1'b0, max_s2}) ? max_s2 : sum_s2[W-1:0];
					res_act = prfa_pkg::ACT_INC;
				end
			end else if (meas_s2 < half) begin
				wr_cur  = (meas_s2 < min_s2) ? min_s2 : meas_s2;
				res_act = prfa_pkg::ACT_DEC;
			end else begin
				res_act = prfa_pkg::ACT_HOLD;
			end
			res_rate = wr_cur;
			res_cnt  = wr_cnt;
		end
	end

	assign out_push     = commit;
	assign out_flow     = tag_s2.flow;
	assign out_rate     = res_rate;
	assign out_action   = res_act;
	assign out_count    = res_cnt;
	assign out_rejected = tag_s2.rejected;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("two items in the update pipeline at once");

	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("stage 1 item did not move to stage 2");

	a_bypass_valid: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> valid_s1)
		else $error("record bypass set without an item in stage 1");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_full) |=> (valid_s2 && $stable(addr_s2)))
		else $error("stage 2 item lost while results were stalled");

endmodule

/* rtl/per_flow_rate_adjuster.sv */
// ----------------------------------------------------------------------------
// Per-flow rate adjuster
// Keeps per-flow rate records and applies additive increase or a drop to the
// measured rate on each update, one result beat for every input beat.
// ----------------------------------------------------------------------------
// Usage:
// Input beats enter through push/full: a beat is taken at a clock edge where
// push is high and full is low. A load beat (op 0) writes a flow's rate,
// limits and step and clears its count; an update beat (op 1) brings a
// measured rate. Results leave through empty/pop: the oldest result sits on
// the result ports while empty is low and is taken when pop is high.
// The active flow count is written through cfg_wr_en/cfg_wr_data while the
// block is idle, which the user must ensure as the block does not enforce
// it; flows at or past it come back with rejected set. Items are handled
// one at a time: the record read is registered into stage 1, the reciprocal
// multiply is registered into stage 2, and the write-back of one item
// overlaps the read of the next. Reset clears the queues, the pipeline and
// the active flow count to zero; the record memory is not cleared and a
// flow must be loaded before use. If pop stays low, the result queue fills,
// the pipeline holds its item and full rises once the two-entry work queue
// is also full.
// ----------------------------------------------------------------------------
module per_flow_rate_adjuster #(
	parameter int MAX_FLOWS = 256,
	parameter int RATE_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [prfa_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                         push,
	output logic                         full,
	input  logic                         op,
	input  logic [prfa_pkg::FLOW_W-1:0]  flow,
	input  logic [RATE_BITS-1:0]         measured_rate,
	input  logic [RATE_BITS-1:0]         load_rate,
	input  logic [RATE_BITS-1:0]         load_min,
	input  logic [RATE_BITS-1:0]         load_max,
	input  logic [RATE_BITS-1:0]         load_step,
	output logic                         empty,
	input  logic                         pop,
	output logic [prfa_pkg::FLOW_W-1:0]  flow_out,
	output logic [RATE_BITS-1:0]         new_rate,
	output logic [prfa_pkg::ACT_W-1:0]   action,
	output logic [prfa_pkg::COUNT_W-1:0] count_out,
	output logic                         rejected
);

	localparam int ADDR_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int MID_W  = $bits(prfa_pkg::item_tag_t) + ADDR_W + 5 * RATE_BITS;
	localparam int OUT_W  = prfa_pkg::FLOW_W + RATE_BITS + prfa_pkg::ACT_W +
	                        prfa_pkg::COUNT_W + 1;

	// Front end to work queue.
	logic                 q_full;
	logic                 q_push;
	prfa_pkg::item_tag_t  q_tag;
	logic [ADDR_W-1:0]    q_addr;
	logic [RATE_BITS-1:0] q_meas, q_load_rate, q_load_min, q_load_max, q_load_step;
	logic [MID_W-1:0]     mid_wr_data;

	// Work queue to back end.
	logic                 mid_empty;
	logic                 mid_pop;
	logic [MID_W-1:0]     mid_rd_data;
	prfa_pkg::item_tag_t  mid_tag;
	logic [ADDR_W-1:0]    mid_addr;
	logic [RATE_BITS-1:0] mid_meas, mid_load_rate, mid_load_min, mid_load_max;
	logic [RATE_BITS-1:0] mid_load_step;

	// Back end to result queue.
	logic                         res_full;
	logic                         res_push;
	logic [prfa_pkg::FLOW_W-1:0]  res_flow;
	logic [RATE_BITS-1:0]         res_rate;
	logic [prfa_pkg::ACT_W-1:0]   res_action;
	logic [prfa_pkg::COUNT_W-1:0] res_count;
	logic                         res_rejected;
	logic [OUT_W-1:0]             res_wr_data;
	logic [OUT_W-1:0]             res_rd_data;

	prfa_front #(
		.MAX_FLOWS (MAX_FLOWS),
		.RATE_BITS (RATE_BITS),
		.ADDR_W    (ADDR_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.push          (push),
		.full          (full),
		.op            (op),
		.flow          (flow),
		.measured_rate (measured_rate),
		.load_rate     (load_rate),
		.load_min      (load_min),
		.load_max      (load_max),
		.load_step     (load_step),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_tag         (q_tag),
		.q_addr        (q_addr),
		.q_meas        (q_meas),
		.q_load_rate   (q_load_rate),
		.q_load_min    (q_load_min),
		.q_load_max    (q_load_max),
		.q_load_step   (q_load_step)
	);

	assign mid_wr_data = {q_tag, q_addr, q_meas, q_load_rate, q_load_min,
	                      q_load_max, q_load_step};

	// Two entries let the front take a beat while the back works on one.
	prfa_fifo #(
		.WIDTH (MID_W),
		.DEPTH (2)
	) u_work_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (mid_wr_data),
		.full    (q_full),
		.pop     (mid_pop),
		.rd_data (mid_rd_data),
		.empty   (mid_empty)
	);

	assign {mid_tag, mid_addr, mid_meas, mid_load_rate, mid_load_min,
	        mid_load_max, mid_load_step} = mid_rd_data;

	prfa_back #(
		.MAX_FLOWS (MAX_FLOWS),
		.RATE_BITS (RATE_BITS),
		.ADDR_W    (ADDR_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_empty     (mid_empty),
		.in_pop       (mid_pop),
		.in_tag       (mid_tag),
		.in_addr      (mid_addr),
		.in_meas      (mid_meas),
		.in_load_rate (mid_load_rate),
		.in_load_min  (mid_load_min),
		.in_load_max  (mid_load_max),
		.in_load_step (mid_load_step),
		.out_full     (res_full),
		.out_push     (res_push),
		.out_flow     (res_flow),
		.out_rate     (res_rate),
		.out_action   (res_action),
		.out_count    (res_count),
		.out_rejected (res_rejected)
	);

	assign res_wr_data = {res_flow, res_rate, res_action, res_count, res_rejected};

	// Result queue: the back end keeps working while a result waits for pop.
	prfa_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (2)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wr_data),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_rd_data),
		.empty   (empty)
	);

	assign {flow_out, new_rate, action, count_out, rejected} = res_rd_data;

endmodule
